/* design/scmac_pkg.sv */
// ----------------------------------------------------------------------------
// scmac_pkg
// Shared types and constants for the Simon CBC-MAC core.
// ----------------------------------------------------------------------------
package scmac_pkg;

   localparam int WordBitsDefault  = 32;
   localparam int KeyWordsDefault  = 4;
   localparam int RoundsDefault    = 44;
   localparam int SeqSelectDefault = 3;

   localparam int SeqLen    = 62;
   localparam int SeqBits   = 6;
   localparam int SeqCount  = 5;
   localparam int KeyRegs   = 4;
   localparam int PortBits  = 32;

   // round function and key schedule rotation amounts, and key schedule constant
   localparam int RotA     = 1;
   localparam int RotB     = 8;
   localparam int RotC     = 2;
   localparam int KeyRot   = 3;
   localparam int KeyConst = 3;

   localparam int CsrIndexBits = 2;
   typedef logic [CsrIndexBits-1:0] csr_index_type;

   localparam csr_index_type CSR_KEY_WORD0 = 2'd0;
   localparam csr_index_type CSR_KEY_WORD1 = 2'd1;
   localparam csr_index_type CSR_KEY_WORD2 = 2'd2;
   localparam csr_index_type CSR_KEY_WORD3 = 2'd3;

   // round constant sequences, element 0 leftmost
   localparam logic [0:SeqLen-1] ZSEQ [SeqCount] = '{
      62'b1111101000100101011000011100110_1111101000100101011000011100110,
      62'b1000111011111001001100001011010_1000111011111001001100001011010,
      62'b1010111101_1100000011_0100100110_0010100001_0001111110_0101101100_11,
      62'b1101101110_1011000110_0101111000_0001001000_1010011100_1101000011_11,
      62'b1101000111_1001101011_0110001000_0001011100_0011001010_0100111011_11
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPAND,
      ST_LOAD,
      ST_ROUND,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [PortBits-1:0] data_word0;
      logic [PortBits-1:0] data_word1;
      logic                first_block;
      logic                last_block;
   } req_type;

   typedef struct packed {
      logic [PortBits-1:0] mac_word0;
      logic [PortBits-1:0] mac_word1;
   } rsp_type;

endpackage

/* design/simon_cbc_mac_core.sv */
// ----------------------------------------------------------------------------
// simon_cbc_mac_core
// CBC-MAC over the Simon block cipher; round keys live in a one-port-read memory.
// ----------------------------------------------------------------------------
// per block: a load state for the key memory read, then one round per cycle;
//    after a last block's final round, emit registers the mac onto rsp once free
// first block: adds key expansion ahead of the load, one key written per cycle
// a new block is taken only in idle, once the previous block's rounds (and emit
//    after a last block) are done, as set by the single round unit
// reset: synchronous; clears control, key registers and chaining value
module simon_cbc_mac_core #(
   parameter int WORD_BITS       = scmac_pkg::WordBitsDefault,
   parameter int KEY_WORDS       = scmac_pkg::KeyWordsDefault,
   parameter int ROUNDS          = scmac_pkg::RoundsDefault,
   parameter int SEQUENCE_SELECT = scmac_pkg::SeqSelectDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  scmac_pkg::req_type       req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output scmac_pkg::rsp_type       rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  scmac_pkg::csr_index_type csr_index,
   input  logic [scmac_pkg::PortBits-1:0] csr_data
);
   import scmac_pkg::*;

   localparam int W         = WORD_BITS;
   localparam int RoundBits = $clog2(ROUNDS);
   localparam int SeqSel    = SEQUENCE_SELECT % SeqCount;
   localparam int Idx3      = (KEY_WORDS >= 3) ? KEY_WORDS - 3 : 0;

   localparam logic [RoundBits-1:0] LastRound = RoundBits'(ROUNDS - 1);
   localparam logic [RoundBits-1:0] KeyCount  = RoundBits'(KEY_WORDS);

   state_type state_ff, state_in;

   logic [PortBits-1:0]  key_ff [KeyRegs];
   logic [W-1:0]         chain0_ff, chain0_in;
   logic [W-1:0]         chain1_ff, chain1_in;
   logic [W-1:0]         x_ff, x_in;
   logic [W-1:0]         y_ff, y_in;
   logic                 last_ff, last_in;
   logic [RoundBits-1:0] round_ff, round_in;
   logic [RoundBits-1:0] exp_ff, exp_in;
   logic [SeqBits-1:0]   zidx_ff, zidx_in;
   logic [W-1:0]         win_ff [KEY_WORDS];
   logic [W-1:0]         win_in [KEY_WORDS];
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic [W-1:0]         rk_mem [ROUNDS];
   logic [W-1:0]         rk_q_ff;
   logic [RoundBits-1:0] rd_addr;
   logic                 rk_we;
   logic [W-1:0]         newk;
   logic [W-1:0]         kt0, kt1, kt2;
   logic [W-1:0]         x_round;
   logic                 req_fire;
   logic                 rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // key schedule step from the window of the last KEY_WORDS keys; the first KEY_WORDS keys come from the key registers
   always_comb begin
      kt0 = {win_ff[KEY_WORDS-1][KeyRot-1:0], win_ff[KEY_WORDS-1][W-1:KeyRot]};
      kt1 = (KEY_WORDS == 4) ? (kt0 ^ win_ff[Idx3]) : kt0;
      kt2 = kt1 ^ {kt1[0], kt1[W-1:1]};
      if (exp_ff < KeyCount) begin
         newk = W'(key_ff[exp_ff[1:0]]);
      end else begin
         newk = ~win_ff[0] ^ kt2 ^ W'(ZSEQ[SeqSel][zidx_ff]) ^ W'(KeyConst);
      end
   end

   // one simon round
   assign x_round = y_ff
                  ^ ({x_ff[W-1-RotA:0], x_ff[W-1:W-RotA]}
                     & {x_ff[W-1-RotB:0], x_ff[W-1:W-RotB]})
                  ^ {x_ff[W-1-RotC:0], x_ff[W-1:W-RotC]}
                  ^ rk_q_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = req_data.first_block ? ST_EXPAND : ST_LOAD;
            end
         end
         ST_EXPAND: begin
            if (exp_ff == LastRound) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (round_ff == LastRound) begin
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      chain0_in    = chain0_ff;
      chain1_in    = chain1_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      last_in      = last_ff;
      round_in     = round_ff;
      exp_in       = exp_ff;
      zidx_in      = zidx_ff;
      win_in       = win_ff;
      rk_we        = 1'b0;
      rd_addr      = '0;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // a first block starts from a zero chain
               x_in    = W'(req_data.data_word1)
                       ^ (req_data.first_block ? '0 : chain1_ff);
               y_in    = W'(req_data.data_word0)
                       ^ (req_data.first_block ? '0 : chain0_ff);
               last_in = req_data.last_block;
               exp_in  = '0;
               zidx_in = '0;
            end
         end
         ST_EXPAND: begin
            rk_we = 1'b1;
            for (int i = 0; i < KEY_WORDS - 1; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[KEY_WORDS-1] = newk;
            if (exp_ff != LastRound) begin
               exp_in = exp_ff + 1'b1;
            end
            if (exp_ff >= KeyCount) begin
               zidx_in = (zidx_ff == SeqBits'(SeqLen - 1)) ? '0 : zidx_ff + 1'b1;
            end
         end
         ST_LOAD: begin
            round_in = '0;
         end
         ST_ROUND: begin
            x_in = x_round;
            y_in = x_ff;
            if (round_ff == LastRound) begin
               round_in  = '0;
               chain0_in = x_ff;
               chain1_in = x_round;
            end else begin
               round_in = round_ff + 1'b1;
               rd_addr  = round_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.mac_word0 = PortBits'(chain0_ff);
               rsp_data_in.mac_word1 = PortBits'(chain1_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chain0_ff    <= '0;
         chain1_ff    <= '0;
         round_ff     <= '0;
         exp_ff       <= '0;
         zidx_ff      <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < KeyRegs; i++) begin
            key_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         chain0_ff    <= chain0_in;
         chain1_ff    <= chain1_in;
         round_ff     <= round_in;
         exp_ff       <= exp_in;
         zidx_ff      <= zidx_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KEY_WORD0: key_ff[0] <= csr_data;
               CSR_KEY_WORD1: key_ff[1] <= csr_data;
               CSR_KEY_WORD2: key_ff[2] <= csr_data;
               CSR_KEY_WORD3: key_ff[3] <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      win_ff      <= win_in;
      rsp_data_ff <= rsp_data_in;
   end

   // round key store
   always_ff @(posedge clock) begin
      if (rk_we) begin
         rk_mem[exp_ff] <= newk;
      end
      rk_q_ff <= rk_mem[rd_addr];
   end

   a_plain_block_loads: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_data.first_block |=> state_ff == ST_LOAD)
      else $error("block without first flag did not go to key read");

   a_round_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |-> round_ff <= LastRound)
      else $error("round counter past last round");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT)
      else $error("result raised outside emit");

   a_round_starts_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |=> state_ff == ST_ROUND && round_ff == '0)
      else $error("encryption did not start at round zero");

endmodule
